@@ src/hfn_pkg.sv @@
// ----------------------------------------------------------------------------
// hfn_pkg
// shared types and constants of the heightfield normal engine
// ----------------------------------------------------------------------------
package hfn_pkg;

  // default sizes
  localparam int unsigned DefMaxWidth     = 256;
  localparam int unsigned DefMaxDepth     = 256;
  localparam int unsigned DefFractionBits = 14;

  // fixed field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned PosW    = 8;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned DimW    = 13;   // holds any grid size up to 4096
  localparam int unsigned DiffW   = 17;   // difference of two samples
  localparam int unsigned SqW     = 34;   // square of a difference
  localparam int unsigned SumW    = 36;   // sum of squares plus bias
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 48;

  // vertical component 64 squared
  localparam logic [SumW-1:0] YSquare = SumW'(4096);

  // input kinds carried in tuser
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // register indexes
  localparam logic RegGridWidth = 1'b0;
  localparam logic RegGridDepth = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_L,
    ST_RD_R,
    ST_RD_U,
    ST_RD_D,
    ST_SQX,
    ST_SQZ,
    ST_SUM,
    ST_ITA,
    ST_ITB,
    ST_DONE
  } state_e;

endpackage

@@ src/heightfield_normal_engine.sv @@
// ----------------------------------------------------------------------------
// heightfield_normal_engine
// height sample store with central difference surface normal queries
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser is the command (write or query), tdata carries
// the grid position and the sample. A write stores one sample in the height
// memory. A query reads the four neighbours of the clamped position, one
// per cycle over the single memory port, squares the two differences and
// then finds the three rounded components with a bit-serial search, one
// result bit per step, all three lanes in parallel. A query outside the grid
// goes straight to the result. The engine goes back to idle, where it takes
// the next item, once the result has gone to the output register, so a
// result waiting on m_axis does not hold back the next item until that one
// is finished as well.
// Reset empties the output register and restores both grid registers to
// 256; the height memory holds nothing defined until written.
// While m_axis_tready is low the result holds and s_axis_tready stays low
// as soon as a further result is ready to leave.
// ----------------------------------------------------------------------------
module heightfield_normal_engine
  import hfn_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = DefMaxWidth,
  parameter int unsigned MAX_DEPTH     = DefMaxDepth,
  parameter int unsigned FRACTION_BITS = DefFractionBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // item stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // pos_x, pos_z, height_sample
  input  logic                s_axis_tuser,   // cmd
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // normal_x, normal_y, normal_z, pad
  output logic                m_axis_tuser    // out_of_grid
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_DEPTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned WideW = 2 * FRACTION_BITS + 40;
  localparam int unsigned NW    = FRACTION_BITS + 1;
  localparam int unsigned BitW  = $clog2(FRACTION_BITS + 1);

  // field unpacking
  logic [PosW-1:0]    in_x, in_z;
  logic [SampleW-1:0] in_h;
  assign in_x = s_axis_tdata[PosW-1:0];
  assign in_z = s_axis_tdata[2*PosW-1:PosW];
  assign in_h = s_axis_tdata[2*PosW+SampleW-1:2*PosW];

  // configuration registers
  logic [CfgW-1:0] gw_cfg_q, gd_cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_cfg_q <= CfgW'(256);
      gd_cfg_q <= CfgW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGridWidth: gw_cfg_q <= cfg_data_i;
        RegGridDepth: gd_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective grid size
  logic [DimW-1:0] gw, gd, gw_raw, gd_raw;
  assign gw_raw = DimW'(gw_cfg_q);
  assign gd_raw = DimW'(gd_cfg_q);
  always_comb begin
    gw = gw_raw;
    if (gw_raw < DimW'(3)) gw = DimW'(3);
    else if (gw_raw > DimW'(MAX_WIDTH)) gw = DimW'(MAX_WIDTH);
    gd = gd_raw;
    if (gd_raw < DimW'(3)) gd = DimW'(3);
    else if (gd_raw > DimW'(MAX_DEPTH)) gd = DimW'(MAX_DEPTH);
  end

  // clamped neighbour centre
  logic [DimW-1:0] cx_n, cz_n;
  logic            outside;
  always_comb begin
    outside = (DimW'(in_x) >= gw) || (DimW'(in_z) >= gd);
    cx_n = (in_x == '0) ? DimW'(1) : DimW'(in_x);
    if (cx_n > gw - DimW'(2)) cx_n = gw - DimW'(2);
    cz_n = (in_z == '0) ? DimW'(1) : DimW'(in_z);
    if (cz_n > gd - DimW'(2)) cz_n = gd - DimW'(2);
  end

  state_e state_q, state_d;
  logic [DimW-1:0] cx_q, cz_q;
  logic            accept, out_free;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // memory address and write select
  logic               mem_we;
  logic [AddrW-1:0]   mem_addr;
  logic [SampleW-1:0] rd_q;
  always_comb begin
    int unsigned ax, az;
    ax = 0;
    az = 0;
    mem_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        ax = int'(in_x);
        az = int'(in_z);
        mem_we = accept && (s_axis_tuser == CmdWrite) &&
                 (int'(in_x) < MAX_WIDTH) && (int'(in_z) < MAX_DEPTH);
      end
      ST_RD_L: begin ax = int'(cx_q) - 1; az = int'(cz_q); end
      ST_RD_R: begin ax = int'(cx_q) + 1; az = int'(cz_q); end
      ST_RD_U: begin ax = int'(cx_q); az = int'(cz_q) - 1; end
      ST_RD_D: begin ax = int'(cx_q); az = int'(cz_q) + 1; end
      default: ;
    endcase
    mem_addr = AddrW'(az * MAX_WIDTH + ax);
  end

  // height memory, one port
  logic [SampleW-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= in_h;
    else rd_q <= mem[mem_addr];
  end

  // difference and square datapath
  logic signed [DiffW-1:0] hl_q, hu_q, dx_q, dz_q;
  logic [SqW-1:0]          sqx_q, sqz_q;
  logic [SumW-1:0]         s_q;
  logic                    err_q;
  logic [BitW-1:0]         b_q;

  // search lanes: n, n^2*s, n*s and trial values
  logic [NW-1:0]    n_q  [3];
  logic [WideW-1:0] a_q  [3];
  logic [WideW-1:0] bb_q [3];
  logic [WideW-1:0] at_q [3];
  logic [WideW-1:0] bt_q [3];
  logic [WideW-1:0] rhs  [3];

  assign rhs[0] = WideW'(sqx_q) << (2 * FRACTION_BITS + 2);
  assign rhs[1] = WideW'(YSquare) << (2 * FRACTION_BITS + 2);
  assign rhs[2] = WideW'(sqz_q) << (2 * FRACTION_BITS + 2);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && s_axis_tuser == CmdQuery) begin
        state_d = outside ? ST_DONE : ST_RD_L;
      end
      ST_RD_L: state_d = ST_RD_R;
      ST_RD_R: state_d = ST_RD_U;
      ST_RD_U: state_d = ST_RD_D;
      ST_RD_D: state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQZ;
      ST_SQZ:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_ITA;
      ST_ITA:  state_d = ST_ITB;
      ST_ITB:  state_d = (b_q == '0) ? ST_DONE : ST_ITA;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cx_q  <= cx_n;
        cz_q  <= cz_n;
        err_q <= outside;
        dx_q  <= '0;
        dz_q  <= '0;
        for (int i = 0; i < 3; i++) n_q[i] <= '0;
      end
      ST_RD_R: hl_q <= DiffW'(signed'(rd_q));
      ST_RD_U: dx_q <= hl_q - DiffW'(signed'(rd_q));
      ST_RD_D: hu_q <= DiffW'(signed'(rd_q));
      ST_SQX: begin
        dz_q  <= hu_q - DiffW'(signed'(rd_q));
        sqx_q <= SqW'(dx_q * dx_q);
      end
      ST_SQZ: sqz_q <= SqW'(dz_q * dz_q);
      ST_SUM: begin
        s_q <= SumW'(sqx_q) + SumW'(sqz_q) + YSquare;
        b_q <= BitW'(FRACTION_BITS);
        for (int i = 0; i < 3; i++) begin
          n_q[i]  <= '0;
          a_q[i]  <= '0;
          bb_q[i] <= '0;
        end
      end
      // trial t = n + 2^b: t^2 s and t s from shifts and adds
      ST_ITA: begin
        for (int i = 0; i < 3; i++) begin
          at_q[i] <= a_q[i] + (bb_q[i] << (b_q + 1'b1)) + (WideW'(s_q) << (2 * b_q));
          bt_q[i] <= bb_q[i] + (WideW'(s_q) << b_q);
        end
      end
      // keep the bit when (2t-1)^2 s does not exceed 4 mag^2 2^2F
      ST_ITB: begin
        for (int i = 0; i < 3; i++) begin
          if (!n_q[i][FRACTION_BITS] &&
              ((at_q[i] << 2) - (bt_q[i] << 2) + WideW'(s_q)) <= rhs[i]) begin
            n_q[i]  <= n_q[i] | (NW'(1) << b_q);
            a_q[i]  <= at_q[i];
            bb_q[i] <= bt_q[i];
          end
        end
        b_q <= b_q - 1'b1;
      end
      default: ;
    endcase
  end

  // signed results
  logic [31:0] nx_pos, nz_pos, ny_pos;
  logic [15:0] nx_o, nz_o;
  assign nx_pos = 32'(n_q[0]);
  assign ny_pos = 32'(n_q[1]);
  assign nz_pos = 32'(n_q[2]);
  assign nx_o = dx_q[DiffW-1] ? 16'(32'd0 - nx_pos) : nx_pos[15:0];
  assign nz_o = dz_q[DiffW-1] ? 16'(32'd0 - nz_pos) : nz_pos[15:0];

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      m_axis_tuser <= err_q;
      m_axis_tdata <= {1'b0, nz_o, ny_pos[14:0], nx_o};
    end
  end

endmodule

@@ src/hfn_checker.sv @@
// ----------------------------------------------------------------------------
// hfn_checker
// port level checks of the heightfield normal engine
// ----------------------------------------------------------------------------
module hfn_checker
  import hfn_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a write transfer never raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CmdWrite |=> !$rose(m_axis_tvalid))
    else $error("result after a write");

  // a query transfer makes the engine busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CmdQuery |=> !s_axis_tready)
    else $error("input taken during a query");

  // outside query gives a zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero normal on an outside query");

endmodule

bind heightfield_normal_engine hfn_checker u_hfn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
